FILE: hw/rtl/iosc_pkg.sv
package iosc_pkg;

   localparam int KIND_W = 4;
   localparam int CAT_W = 3;
   localparam int OPC_W = 8;
   localparam int ROW_W = 5;

   localparam logic [KIND_W-1:0] KIND_LBRK = 4'd9;
   localparam logic [KIND_W-1:0] KIND_COMMENT = 4'd5;
   localparam logic [KIND_W-1:0] KIND_REG = 4'd6;
   localparam logic [KIND_W-1:0] KIND_COMMA = 4'd7;
   localparam logic [KIND_W-1:0] KIND_NUMBER = 4'd8;
   localparam logic [KIND_W-1:0] KIND_RBRK = 4'd10;
   localparam logic [KIND_W-1:0] KIND_EXCL = 4'd11;
   localparam logic [KIND_W-1:0] KIND_IDENT = 4'd12;
   localparam logic [KIND_W-1:0] KIND_END = 4'd14;

   localparam logic [ROW_W-1:0] ROW_START = 5'd0;

   localparam logic [OPC_W-1:0] FORM_NONE = 8'h00;
   localparam logic [OPC_W-1:0] FORM_MOV_REG = 8'h70;
   localparam logic [OPC_W-1:0] FORM_MOV_IMM = 8'h80;
   localparam logic [OPC_W-1:0] FORM_BR_IND = 8'ha0;
   localparam logic [OPC_W-1:0] FORM_BR_DIR = 8'h90;
   localparam logic [OPC_W-1:0] FORM_BR_EXCL = 8'hb0;
   localparam logic [OPC_W-1:0] FORM_LS_PCREL = 8'h08;
   localparam logic [OPC_W-1:0] FORM_LS_EXCL = 8'h09;
   localparam logic [OPC_W-1:0] FORM_LS_POSTREG = 8'h07;

   typedef enum logic [CAT_W-1:0] {
      TBL_ARITH = 3'd0,
      TBL_MOVCMP = 3'd1,
      TBL_BRANCH = 3'd2,
      TBL_LDRSTR = 3'd3,
      TBL_MISC = 3'd4
   } table_type;

   typedef struct packed {
      logic accept;
      logic [OPC_W-1:0] code;
   } form_type;

   typedef struct packed {
      logic syntax_ok;
      logic [OPC_W-1:0] coded_form;
   } result_type;

   function automatic table_type table_sel(logic [CAT_W-1:0] cat);
      table_type tbl;
      case (cat)
         3'd1: tbl = TBL_MOVCMP;
         3'd2: tbl = TBL_BRANCH;
         3'd3: tbl = TBL_LDRSTR;
         3'd4: tbl = TBL_MISC;
         default: tbl = TBL_ARITH;
      endcase
      return tbl;
   endfunction

   // A zero result means there is no transition; the start row is never a target.
   function automatic logic [ROW_W-1:0] next_row(table_type tbl, logic [ROW_W-1:0] row,
                                                 logic [KIND_W-1:0] kind);
      logic [ROW_W-1:0] nxt;
      nxt = ROW_START;
      case (tbl)
         TBL_ARITH: begin
            case (row)
               5'd0: if (kind == KIND_REG) nxt = 5'd1;
               5'd1: if (kind == KIND_COMMA) nxt = 5'd2;
               5'd2: if (kind == KIND_REG) nxt = 5'd3;
               5'd3: if (kind == KIND_COMMA) nxt = 5'd4;
               5'd4: if (kind == KIND_REG || kind == KIND_NUMBER) nxt = 5'd5;
               default: nxt = ROW_START;
            endcase
         end
         TBL_MOVCMP: begin
            case (row)
               5'd0: if (kind == KIND_REG) nxt = 5'd1;
               5'd1: if (kind == KIND_COMMA) nxt = 5'd2;
               5'd2: begin
                  if (kind == KIND_REG) nxt = 5'd3;
                  else if (kind == KIND_NUMBER || kind == KIND_IDENT) nxt = 5'd4;
               end
               default: nxt = ROW_START;
            endcase
         end
         TBL_BRANCH: begin
            case (row)
               5'd0: begin
                  if (kind == KIND_NUMBER || kind == KIND_IDENT) nxt = 5'd4;
                  else if (kind == KIND_LBRK) nxt = 5'd1;
                  else if (kind == KIND_EXCL) nxt = 5'd5;
               end
               5'd1: if (kind == KIND_REG) nxt = 5'd2;
               5'd2: if (kind == KIND_RBRK) nxt = 5'd3;
               5'd5: if (kind == KIND_IDENT) nxt = 5'd6;
               default: nxt = ROW_START;
            endcase
         end
         TBL_LDRSTR: begin
            case (row)
               5'd0: if (kind == KIND_REG) nxt = 5'd1;
               5'd1: if (kind == KIND_COMMA) nxt = 5'd2;
               5'd2: begin
                  if (kind == KIND_NUMBER || kind == KIND_IDENT) nxt = 5'd8;
                  else if (kind == KIND_LBRK) nxt = 5'd3;
                  else if (kind == KIND_EXCL) nxt = 5'd20;
               end
               5'd3: if (kind == KIND_REG) nxt = 5'd4;
               5'd4: begin
                  if (kind == KIND_COMMA) nxt = 5'd5;
                  else if (kind == KIND_RBRK) nxt = 5'd9;
               end
               5'd5: begin
                  if (kind == KIND_REG) nxt = 5'd6;
                  else if (kind == KIND_NUMBER) nxt = 5'd7;
               end
               5'd6: begin
                  if (kind == KIND_COMMA) nxt = 5'd17;
                  else if (kind == KIND_RBRK) nxt = 5'd11;
               end
               5'd7: if (kind == KIND_RBRK) nxt = 5'd10;
               5'd9: if (kind == KIND_COMMA) nxt = 5'd14;
               5'd10: if (kind == KIND_EXCL) nxt = 5'd12;
               5'd11: if (kind == KIND_EXCL) nxt = 5'd13;
               5'd14: begin
                  if (kind == KIND_REG) nxt = 5'd16;
                  else if (kind == KIND_NUMBER) nxt = 5'd15;
               end
               5'd17: if (kind == KIND_NUMBER) nxt = 5'd18;
               5'd18: if (kind == KIND_RBRK) nxt = 5'd19;
               5'd20: if (kind == KIND_IDENT) nxt = 5'd21;
               default: nxt = ROW_START;
            endcase
         end
         TBL_MISC: begin
            case (row)
               5'd0: begin
                  if (kind == KIND_REG) nxt = 5'd2;
                  else if (kind == KIND_NUMBER) nxt = 5'd1;
               end
               5'd2: if (kind == KIND_COMMA) nxt = 5'd3;
               5'd3: if (kind == KIND_REG) nxt = 5'd4;
               default: nxt = ROW_START;
            endcase
         end
         default: nxt = ROW_START;
      endcase
      return nxt;
   endfunction

   function automatic form_type form_code(table_type tbl, logic [ROW_W-1:0] row);
      form_type fc;
      fc = '{accept: 1'b0, code: FORM_NONE};
      case (tbl)
         TBL_ARITH: begin
            if (row == 5'd5) fc = '{accept: 1'b1, code: FORM_NONE};
         end
         TBL_MOVCMP: begin
            case (row)
               5'd3: fc = '{accept: 1'b1, code: FORM_MOV_REG};
               5'd4: fc = '{accept: 1'b1, code: FORM_MOV_IMM};
               default: fc = '{accept: 1'b0, code: FORM_NONE};
            endcase
         end
         TBL_BRANCH: begin
            case (row)
               5'd3: fc = '{accept: 1'b1, code: FORM_BR_IND};
               5'd4: fc = '{accept: 1'b1, code: FORM_BR_DIR};
               5'd6: fc = '{accept: 1'b1, code: FORM_BR_EXCL};
               default: fc = '{accept: 1'b0, code: FORM_NONE};
            endcase
         end
         TBL_LDRSTR: begin
            case (row)
               5'd8: fc = '{accept: 1'b1, code: 8'h00};
               5'd9: fc = '{accept: 1'b1, code: 8'h01};
               5'd10: fc = '{accept: 1'b1, code: 8'h02};
               5'd11: fc = '{accept: 1'b1, code: 8'h03};
               5'd12: fc = '{accept: 1'b1, code: 8'h04};
               5'd13: fc = '{accept: 1'b1, code: 8'h05};
               5'd15: fc = '{accept: 1'b1, code: 8'h06};
               5'd16: fc = '{accept: 1'b1, code: FORM_LS_POSTREG};
               5'd19: fc = '{accept: 1'b1, code: FORM_LS_PCREL};
               5'd21: fc = '{accept: 1'b1, code: FORM_LS_EXCL};
               default: fc = '{accept: 1'b0, code: FORM_NONE};
            endcase
         end
         TBL_MISC: begin
            if (row == 5'd1 || row == 5'd4) fc = '{accept: 1'b1, code: FORM_NONE};
         end
         default: fc = '{accept: 1'b0, code: FORM_NONE};
      endcase
      return fc;
   endfunction

endpackage

FILE: hw/rtl/instruction_operand_syntax_checker_top.sv
// Operand syntax checker for assembler instructions.
// The req channel carries one token per item from a lexer. The first token
// of an instruction is the instruction token: it loads the table category and
// base opcode. Later tokens walk the selected transition table; a token with
// no transition marks the instruction failed until it closes. An end or
// comment token closes the instruction and yields exactly one rsp item with
// the syntax flag and the coded form; other tokens yield no rsp item.
// Throughput is one token per cycle while req_tready is high. A token waits
// in the input register while the table lookup runs; the result of a closing
// token then enters a two-entry output buffer, which drives rsp_tvalid.
// When the receiver stalls, the buffer absorbs up to two results;
// after that a closing token waits in the input register and req_tready
// drops, while non-closing tokens keep flowing until then.
// Reset clears the buffer and returns the checker to awaiting an instruction
// token; it takes effect on the next rising clock edge.
module instruction_operand_syntax_checker_top
   import iosc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] base_opcode
   input  logic [6:0]  req_tuser,  // [3:0] token_kind, [6:4] category
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [7:0] coded_form
   output logic        rsp_tuser   // [0] syntax_ok
);

   logic       res_push;
   logic       res_ready;
   result_type res_item;
   result_type out_item;

   iosc_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_kind     (req_tuser[3:0]),
      .in_category (req_tuser[6:4]),
      .in_opcode   (req_tdata),
      .res_push    (res_push),
      .res_ready   (res_ready),
      .res_item    (res_item)
   );

   iosc_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (res_push),
      .push_ready (res_ready),
      .push_item  (res_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (out_item)
   );

   assign rsp_tdata = out_item.coded_form;
   assign rsp_tuser = out_item.syntax_ok;

endmodule

FILE: hw/rtl/iosc_checker.sv
module iosc_checker
   import iosc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [KIND_W-1:0] in_kind,
   input  logic [CAT_W-1:0]  in_category,
   input  logic [OPC_W-1:0]  in_opcode,
   output logic              res_push,
   input  logic              res_ready,
   output result_type        res_item
);

   logic              s1_valid_ff, s1_valid_in;
   logic [KIND_W-1:0] s1_kind_ff;
   logic [CAT_W-1:0]  s1_cat_ff;
   logic [OPC_W-1:0]  s1_opc_ff;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic              failed_ff, failed_in;
   logic              awaiting_ff, awaiting_in;
   logic [CAT_W-1:0]  held_cat_ff, held_cat_in;
   logic [OPC_W-1:0]  held_opc_ff, held_opc_in;

   logic              s1_closing;
   logic              s1_advance;
   table_type         tbl;
   logic [ROW_W-1:0]  nxt_row;
   form_type          fc;

   assign s1_closing = (s1_kind_ff == KIND_COMMENT) || (s1_kind_ff == KIND_END);
   assign s1_advance = s1_valid_ff && (!s1_closing || res_ready);
   assign in_ready = !s1_valid_ff || s1_advance;
   assign s1_valid_in = in_valid || (s1_valid_ff && !s1_advance);

   assign tbl = table_sel(held_cat_ff);
   assign nxt_row = next_row(tbl, row_ff, s1_kind_ff);
   assign fc = form_code(tbl, row_ff);

   assign res_push = s1_advance && s1_closing;

   always_comb begin
      res_item.syntax_ok = !awaiting_ff && !failed_ff && fc.accept;
      res_item.coded_form = res_item.syntax_ok ? (held_opc_ff | fc.code) : FORM_NONE;
   end

   always_comb begin
      row_in = row_ff;
      failed_in = failed_ff;
      awaiting_in = awaiting_ff;
      held_cat_in = held_cat_ff;
      held_opc_in = held_opc_ff;
      if (s1_advance) begin
         if (s1_closing) begin
            row_in = ROW_START;
            failed_in = 1'b0;
            awaiting_in = 1'b1;
         end else if (awaiting_ff) begin
            held_cat_in = s1_cat_ff;
            held_opc_in = s1_opc_ff;
            row_in = ROW_START;
            failed_in = 1'b0;
            awaiting_in = 1'b0;
         end else if (!failed_ff) begin
            if (nxt_row == ROW_START) begin
               failed_in = 1'b1;
            end else begin
               row_in = nxt_row;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         s1_kind_ff <= in_kind;
         s1_cat_ff <= in_category;
         s1_opc_ff <= in_opcode;
      end
      if (reset) begin
         s1_valid_ff <= 1'b0;
         row_ff <= ROW_START;
         failed_ff <= 1'b0;
         awaiting_ff <= 1'b1;
         held_cat_ff <= '0;
         held_opc_ff <= '0;
      end else begin
         if (in_ready) s1_valid_ff <= s1_valid_in;
         row_ff <= row_in;
         failed_ff <= failed_in;
         awaiting_ff <= awaiting_in;
         held_cat_ff <= held_cat_in;
         held_opc_ff <= held_opc_in;
      end
   end

`ifndef SYNTHESIS
   a_push_only_on_close: assert property (@(posedge clock) disable iff (reset)
      res_push |-> s1_valid_ff && s1_closing)
      else $error("result pushed for a non-closing item");
   a_zero_code_when_bad: assert property (@(posedge clock) disable iff (reset)
      res_push && !res_item.syntax_ok |-> res_item.coded_form == FORM_NONE)
      else $error("nonzero coded form on a rejected instruction");
   a_close_rearms: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_closing |=> awaiting_ff && !failed_ff && row_ff == ROW_START)
      else $error("checker not rearmed after a closing item");
   a_no_fail_while_waiting: assert property (@(posedge clock) disable iff (reset)
      awaiting_ff |-> !failed_ff)
      else $error("failure flag set while awaiting an instruction token");
`endif

endmodule

FILE: hw/rtl/iosc_out_buf.sv
module iosc_out_buf
   import iosc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       push_ready,
   input  result_type push_item,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_item
);

   result_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item = slot_ff[rd_ptr_ff];
   assign do_push = push && push_ready;
   assign do_pop = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 2'd1;
      else if (!do_push && do_pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_item;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end

endmodule
